FILE: rtl/assert_macros.svh
// Assertion macros for the rank unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion %m failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion %m failed");

`endif

FILE: rtl/prank_pkg.sv
// Types and constants for the permutation rank unit.
`timescale 1ns / 1ps

package prank_pkg;

    localparam int ELEM_W   = 4;   // element value width
    localparam int POS_W    = 4;   // position / size width
    localparam int RANK_W   = 29;  // rank width
    localparam int RANK_FIT = 12;  // largest size whose rank fits RANK_W bits

    localparam logic [POS_W-1:0] SIZE_RESET = POS_W'(12);

    typedef struct packed {
        logic last;     // this element completes the permutation
        logic invalid;  // some element of the permutation was bad
    } t_step_res;

endpackage

FILE: rtl/permutation_rank_unit.sv
// Top level of the permutation rank unit: input beat register, walk state, result register.
//
//  channel   dir  beat fields (low bit up)
//  s_axis    in   tdata: element_value[3:0], zero pad to 8 bits
//  m_axis    out  tdata: rank[28:0], zero pad to 32 bits; tuser: invalid
//  cfg       in   i_cfg_wdata: perm_size[3:0], written when i_cfg_we is high
//
// One element per cycle sustained while m_axis takes results. A beat is held in the input
// register, then the combinational step unit (bitmap popcount, 29x4 multiply-add) updates the
// walk state; the last element's step loads the result register that drives m_axis.
// Reset (synchronous, active low) sets perm_size to 12 and clears the walk.
// The input register holds only while a finished rank waits and m_axis stalls.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module permutation_rank_unit import prank_pkg::*; #(
    parameter int MAX_ELEMS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,     // perm_size[3:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // element_value[3:0], pad[7:4]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // rank[28:0], pad[31:29]
    output logic [0:0]  m_axis_tuser     // invalid[0]
);

    localparam int CAP = (MAX_ELEMS < RANK_FIT) ? MAX_ELEMS : RANK_FIT;
    localparam logic [POS_W-1:0] CAP_N = POS_W'(CAP);

    logic [POS_W-1:0]  r_perm_size;
    logic              r_in_valid;
    logic [ELEM_W-1:0] r_in_elem;
    logic [CAP-1:0]    r_seen,  n_seen;
    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [RANK_W-1:0] r_rank,  n_rank;
    logic              r_err,   n_err;
    logic              r_out_valid;
    logic [RANK_W-1:0] r_out_rank;
    logic              r_out_inv;

    logic [POS_W-1:0]  w_n;
    logic [RANK_W-1:0] w_result_rank;
    t_step_res         w_status;
    logic              w_out_free;
    logic              w_advance;
    logic              w_emit;

    assign w_n = (r_perm_size == '0) ? POS_W'(1) :
                 (r_perm_size > CAP_N) ? CAP_N : r_perm_size;

    prank_step #(.CAP(CAP)) u_step (
        .i_n           (w_n),
        .i_elem        (r_in_elem),
        .i_seen        (r_seen),
        .i_pos         (r_pos),
        .i_rank        (r_rank),
        .i_err         (r_err),
        .o_seen        (n_seen),
        .o_pos         (n_pos),
        .o_rank        (n_rank),
        .o_err         (n_err),
        .o_result_rank (w_result_rank),
        .o_status      (w_status)
    );

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && (!w_status.last || w_out_free);
    assign w_emit        = w_advance && w_status.last;
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_size <= SIZE_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_seen      <= '0;
            r_pos       <= '0;
            r_rank      <= '0;
            r_err       <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                r_perm_size <= i_cfg_wdata;
                r_seen      <= '0;
                r_pos       <= '0;
                r_rank      <= '0;
                r_err       <= 1'b0;
            end else if (w_advance) begin
                if (w_status.last) begin
                    r_seen <= '0;
                    r_pos  <= '0;
                    r_rank <= '0;
                    r_err  <= 1'b0;
                end else begin
                    r_seen <= n_seen;
                    r_pos  <= n_pos;
                    r_rank <= n_rank;
                    r_err  <= n_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_elem <= s_axis_tdata[ELEM_W-1:0];
        end
        if (w_emit) begin
            r_out_rank <= w_result_rank;
            r_out_inv  <= w_status.invalid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(32-RANK_W){1'b0}}, r_out_rank};
    assign m_axis_tuser  = r_out_inv;

    // walk position never reaches the permutation size
    `ASSERT_NEVER(a_pos_below_size, i_clk, i_rst_n, r_pos >= w_n)
    // each valid element marks exactly one bitmap bit
    `ASSERT_CLK(a_seen_le_pos, i_clk, i_rst_n, $countones(r_seen) <= r_pos)
    `ASSERT_CLK(a_seen_eq_pos, i_clk, i_rst_n, !r_err |-> ($countones(r_seen) == r_pos))
    // a flagged result carries a zero rank
    `ASSERT_CLK(a_inv_zero, i_clk, i_rst_n,
        (r_out_valid && r_out_inv) |-> (r_out_rank == '0))

endmodule

FILE: rtl/prank_step.sv
// One Lehmer-code step: digit from the seen bitmap, Horner multiply-add of the rank.
`timescale 1ns / 1ps

module prank_step import prank_pkg::*; #(
    parameter int CAP = 12
) (
    input  logic [POS_W-1:0]  i_n,
    input  logic [ELEM_W-1:0] i_elem,
    input  logic [CAP-1:0]    i_seen,
    input  logic [POS_W-1:0]  i_pos,
    input  logic [RANK_W-1:0] i_rank,
    input  logic              i_err,
    output logic [CAP-1:0]    o_seen,
    output logic [POS_W-1:0]  o_pos,
    output logic [RANK_W-1:0] o_rank,
    output logic              o_err,
    output logic [RANK_W-1:0] o_result_rank,
    output t_step_res         o_status
);

    logic [CAP-1:0]            w_hit;
    logic [CAP-1:0]            w_below;
    logic [POS_W-1:0]          w_pos;
    logic [POS_W-1:0]          w_radix;
    logic [POS_W-1:0]          w_count;
    logic [ELEM_W-1:0]         w_digit;
    logic                      w_range_bad;
    logic                      w_repeat;
    logic                      w_good;
    logic [RANK_W+POS_W-1:0]   w_prod;
    logic [RANK_W+POS_W-1:0]   w_sum;
    logic [POS_W-1:0]          w_pos_inc;

    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            w_hit[i]   = (i_elem == ELEM_W'(i + 1));
            w_below[i] = (ELEM_W'(i + 1) < i_elem) && i_seen[i];
        end
    end

    always_comb begin
        w_count = '0;
        for (int i = 0; i < CAP; i++) begin
            w_count = w_count + POS_W'(w_below[i]);
        end
    end

    assign w_pos       = (i_pos >= i_n) ? (i_n - POS_W'(1)) : i_pos;
    assign w_radix     = i_n - w_pos;
    assign w_range_bad = (i_elem == '0) || (i_elem > ELEM_W'(i_n));
    assign w_repeat    = |(w_hit & i_seen);
    assign w_good      = !w_range_bad && !w_repeat;
    assign w_digit     = w_good ? (i_elem - ELEM_W'(1) - ELEM_W'(w_count)) : '0;

    assign w_prod = {{POS_W{1'b0}}, i_rank} * {{RANK_W{1'b0}}, w_radix};
    assign w_sum  = w_prod + {{(RANK_W+POS_W-ELEM_W){1'b0}}, w_digit};

    assign w_pos_inc = w_pos + POS_W'(1);

    assign o_seen        = w_good ? (i_seen | w_hit) : i_seen;
    assign o_pos         = w_pos_inc;
    assign o_rank        = w_sum[RANK_W-1:0];
    assign o_err         = i_err || !w_good;
    assign o_result_rank = o_err ? '0 : (w_sum[RANK_W-1:0] + RANK_W'(1));

    assign o_status.last    = (w_pos_inc >= i_n);
    assign o_status.invalid = o_err;

endmodule

FILE: sim/tb_permutation_rank_unit.sv
// Self-checking testbench for the permutation rank unit.
`timescale 1ns / 1ps

module tb_permutation_rank_unit import prank_pkg::*;;

    localparam int MAX_ELEMS    = 12;
    localparam int SIZE_CAP     = (MAX_ELEMS < RANK_FIT) ? MAX_ELEMS : RANK_FIT;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_ITEMS = 560;
    localparam int STREAM_ITEMS = 90;

    typedef struct {
        logic [RANK_W-1:0] rank;
        logic              invalid;
    } t_rank_result;

    typedef enum int {PERM_CLEAN, PERM_CORRUPT, PERM_NOISE} t_perm_kind;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [3:0]  i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    // shadow of the walk state
    logic [3:0]        size_reg;
    logic [11:0]       seen_mask;
    logic [3:0]        walk_pos;
    logic [RANK_W-1:0] walk_rank;
    logic              walk_bad;

    t_rank_result expected_ranks[$];
    bit calm;                // no idling on either side
    int failures;
    int elems_sent;
    int ranks_checked;
    int invalid_checked;
    int size_writes;

    permutation_rank_unit #(.MAX_ELEMS(MAX_ELEMS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int eff_size(input logic [3:0] sz);
        int n;
        n = (sz == 4'd0) ? 1 : int'(sz);
        if (n > SIZE_CAP) n = SIZE_CAP;
        return n;
    endfunction

    function automatic void clear_walk();
        seen_mask = '0;
        walk_pos  = '0;
        walk_rank = '0;
        walk_bad  = 1'b0;
    endfunction

    // Horner step of the Lehmer rank; queues the rank when the walk completes.
    function automatic void advance_rank(input logic [3:0] v);
        int           n;
        int           p;
        logic [11:0]  vbit;
        logic [3:0]   digit;
        logic [63:0]  acc;
        t_rank_result res;
        n     = eff_size(size_reg);
        p     = (int'(walk_pos) >= n) ? n - 1 : int'(walk_pos);
        digit = '0;
        if (v == 4'd0 || int'(v) > n) begin
            walk_bad = 1'b1;
        end else begin
            vbit = 12'd1 << (v - 4'd1);
            if ((seen_mask & vbit) != '0) begin
                walk_bad = 1'b1;
            end else begin
                digit = 4'(int'(v) - 1 - $countones(seen_mask & (vbit - 12'd1)));
                seen_mask |= vbit;
            end
        end
        acc       = 64'(walk_rank) * 64'(n - p) + 64'(digit);
        walk_rank = acc[RANK_W-1:0];
        p++;
        if (p >= n) begin
            res.invalid = walk_bad;
            res.rank    = walk_bad ? '0 : RANK_W'(walk_rank + 1'b1);
            expected_ranks.insert(expected_ranks.size(), res);
            clear_walk();
        end else begin
            walk_pos = 4'(p);
        end
    endfunction

    task automatic send_elem(input logic [3:0] v);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, v};
        do @(posedge i_clk); while (!s_axis_tready);
        advance_rank(v);
        elems_sent++;
    endtask

    // Block idle: input stream quiet, all ranks back, pipeline flushed.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_ranks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [3:0] sz);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= sz;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        size_reg = sz;
        clear_walk();
        size_writes++;
    endtask

    // Shuffled 1..n, optionally damaged; only the first count elements go out.
    task automatic send_perm(input t_perm_kind kind, input int n, input int count);
        logic [3:0] vals[12];
        logic [3:0] tmp;
        int         j;
        for (int i = 0; i < n; i++) vals[i] = 4'(i + 1);
        for (int i = n - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = vals[i];
            vals[i] = vals[j];
            vals[j] = tmp;
        end
        if (kind == PERM_CORRUPT) begin
            vals[$urandom_range(0, n - 1)] = 4'($urandom_range(0, 15));
        end else if (kind == PERM_NOISE) begin
            for (int i = 0; i < n; i++) vals[i] = 4'($urandom_range(0, 15));
        end
        for (int i = 0; i < count; i++) send_elem(vals[i]);
    endtask

    // Reset size is 12; descending order gives the largest rank, 12!.
    task automatic test_reset_size();
        for (int i = 12; i >= 1; i--) send_elem(4'(i));
    endtask

    task automatic test_special_cases();
        write_size(4'd0);           // zero behaves as one element
        send_elem(4'd1);
        send_elem(4'd0);
        write_size(4'd15);          // saturates to the cap
        send_elem(4'd15);
        send_elem(4'd3);
        write_size(4'd3);           // write in mid-walk must drop the partial walk
        send_elem(4'd1);            // repeated value
        send_elem(4'd1);
        send_elem(4'd2);
        send_elem(4'd2);            // out of range value
        send_elem(4'd15);
        send_elem(4'd1);
        send_elem(4'd3);
        send_elem(4'd1);
        send_elem(4'd2);
    endtask

    task automatic test_random_perms();
        logic [3:0] sz;
        int         n;
        int         pick;
        t_perm_kind kind;
        while (elems_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    sz = 4'd0;
                end
                1: begin
                    sz = 4'd1;
                end
                2: begin
                    sz = 4'd12;
                end
                3: begin
                    sz = 4'($urandom_range(13, 15));
                end
                default: begin
                    sz = 4'($urandom_range(2, 11));
                end
            endcase
            write_size(sz);
            n = eff_size(sz);
            repeat ($urandom_range(3, 10)) begin
                pick = $urandom_range(0, 9);
                kind = (pick < 7) ? PERM_CLEAN : ((pick < 9) ? PERM_CORRUPT : PERM_NOISE);
                send_perm(kind, n, n);
            end
            // leave a partial walk now and then; the next size write clears it
            if (n > 1 && $urandom_range(0, 5) == 0) begin
                send_perm(PERM_CLEAN, n, $urandom_range(1, n - 1));
            end
        end
    endtask

    // Back-to-back beats with no stalls at all.
    task automatic test_streaming();
        int n;
        calm = 1'b1;
        write_size(4'($urandom_range(2, 12)));
        n = eff_size(size_reg);
        while (elems_sent < RANDOM_ITEMS + STREAM_ITEMS) begin
            send_perm(($urandom_range(0, 4) == 0) ? PERM_CORRUPT : PERM_CLEAN, n, n);
        end
    endtask

    initial begin : result_sink
        int           stall_left;
        t_rank_result exp_res;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (expected_ranks.size() == 0) begin
                    $error("unexpected rank beat: rank=%0d invalid=%0d",
                           m_axis_tdata[RANK_W-1:0], m_axis_tuser[0]);
                    failures++;
                end else begin
                    exp_res = expected_ranks.pop_front();
                    if (m_axis_tdata[RANK_W-1:0] !== exp_res.rank) begin
                        $error("rank: expected %0d, actual %0d",
                               exp_res.rank, m_axis_tdata[RANK_W-1:0]);
                        failures++;
                    end
                    if (m_axis_tuser[0] !== exp_res.invalid) begin
                        $error("invalid: expected %0d, actual %0d",
                               exp_res.invalid, m_axis_tuser[0]);
                        failures++;
                    end
                    ranks_checked++;
                    if (exp_res.invalid) invalid_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("Timeout with %0d ranks outstanding", expected_ranks.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        size_reg        = SIZE_RESET;
        clear_walk();
        calm            = 1'b0;
        failures        = 0;
        elems_sent      = 0;
        ranks_checked   = 0;
        invalid_checked = 0;
        size_writes     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_size();
        test_special_cases();
        test_random_perms();
        test_streaming();
        settle();

        $display("Sent %0d element beats over %0d size writes; checked %0d ranks, %0d flagged.",
                 elems_sent, size_writes, ranks_checked, invalid_checked);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
